>>> rtl/bgpd_pkg.sv
// Shared types, codes and constants for the BGP message deframer.
package bgpd_pkg;

    localparam logic [15:0] MAX_MSG_LEN   = 16'd4096;
    localparam logic [15:0] HDR_LEN       = 16'd19;
    localparam logic [15:0] OPEN_MIN_BODY = 16'd10;
    localparam logic [7:0]  MARKER_BYTE   = 8'hFF;
    localparam logic [7:0]  BGP_VERSION   = 8'd4;
    localparam logic [7:0]  PARAM_CAPS    = 8'd2;
    localparam logic [7:0]  CAP_MP        = 8'd1;
    localparam logic [7:0]  CAP_MP_MINLEN = 8'd4;

    // message types
    localparam logic [7:0] MT_OPEN         = 8'd1;
    localparam logic [7:0] MT_UPDATE       = 8'd2;
    localparam logic [7:0] MT_NOTIFICATION = 8'd3;
    localparam logic [7:0] MT_KEEPALIVE    = 8'd4;

    // event codes
    localparam logic [2:0] EV_CAPABILITY  = 3'd0;
    localparam logic [2:0] EV_OPEN_ACCEPT = 3'd1;
    localparam logic [2:0] EV_ESTABLISHED = 3'd2;
    localparam logic [2:0] EV_KEEPALIVE   = 3'd3;
    localparam logic [2:0] EV_UPDATE      = 3'd4;
    localparam logic [2:0] EV_CLOSED      = 3'd5;

    // error codes
    localparam logic [2:0] ERR_NONE         = 3'd0;
    localparam logic [2:0] ERR_MARKER       = 3'd1;
    localparam logic [2:0] ERR_LENGTH       = 3'd2;
    localparam logic [2:0] ERR_OPEN_SHORT   = 3'd3;
    localparam logic [2:0] ERR_VERSION      = 3'd4;
    localparam logic [2:0] ERR_NOTIFICATION = 3'd5;
    localparam logic [2:0] ERR_UNKNOWN_TYPE = 3'd6;

    // reported session state codes
    localparam logic [1:0] SS_OPEN_SENT    = 2'd0;
    localparam logic [1:0] SS_OPEN_CONFIRM = 2'd1;
    localparam logic [1:0] SS_ESTABLISHED  = 2'd2;
    localparam logic [1:0] SS_CLOSED       = 2'd3;

    typedef enum logic [3:0] {
        CONN_OPEN_SENT    = 4'b0001,
        CONN_OPEN_CONFIRM = 4'b0010,
        CONN_ESTABLISHED  = 4'b0100,
        CONN_CLOSED       = 4'b1000
    } t_conn;

    typedef struct packed {
        logic [1:0]  session_state;
        logic [7:0]  cap_safi;
        logic [15:0] cap_afi;
        logic [31:0] peer_router_id;
        logic [15:0] peer_as;
        logic [2:0]  error_code;
        logic [2:0]  event_res;
        logic        last;
    } t_result;

    // up to two results produced by one byte
    typedef struct packed {
        logic [1:0] count;
        t_result    first;
        t_result    second;
    } t_push;

    function automatic logic [1:0] conn_code(t_conn s);
        logic [1:0] c;
        unique case (s)
            CONN_OPEN_SENT:    c = SS_OPEN_SENT;
            CONN_OPEN_CONFIRM: c = SS_OPEN_CONFIRM;
            CONN_ESTABLISHED:  c = SS_ESTABLISHED;
            default:           c = SS_CLOSED;
        endcase
        return c;
    endfunction

endpackage

>>> rtl/bgpd_parser.sv
// Per-byte framing, OPEN parsing and session state machine.
module bgpd_parser (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_accept,
    input  logic [7:0]     i_byte,
    output bgpd_pkg::t_push o_push
);

    logic [15:0]     r_byte_pos,     n_byte_pos;
    logic [15:0]     r_msg_len,      n_msg_len;
    logic [7:0]      r_msg_type,     n_msg_type;
    logic            r_marker_good,  n_marker_good;
    bgpd_pkg::t_conn r_conn,         n_conn;
    logic [7:0]      r_open_ver,     n_open_ver;
    logic [15:0]     r_param_cursor, n_param_cursor;
    logic [8:0]      r_param_end,    n_param_end;
    logic [15:0]     r_cap_cursor,   n_cap_cursor;
    logic [7:0]      r_cap_header,   n_cap_header;
    logic [15:0]     r_afi_shift,    n_afi_shift;
    logic [15:0]     r_remote_as,    n_remote_as;
    logic [31:0]     r_remote_id,    n_remote_id;
    logic [7:0]      r_param_type,   n_param_type;
    logic [15:0]     r_data_start,   n_data_start;
    logic            r_outer_live,   n_outer_live;
    logic            r_inner_live,   n_inner_live;
    logic            r_data_live,    n_data_live;

    logic        put_cap;
    logic [15:0] cap_afi;
    logic [7:0]  cap_safi;
    logic        put_end;
    logic [2:0]  end_ev;
    logic [2:0]  end_err;
    logic [15:0] pos;
    logic [15:0] b;
    logic [15:0] body_bytes;
    logic [15:0] fin_body_len;
    logic [16:0] b_plus2;
    logic [15:0] off;
    logic [15:0] nxt;

    always_comb begin
        n_byte_pos     = r_byte_pos;
        n_msg_len      = r_msg_len;
        n_msg_type     = r_msg_type;
        n_marker_good  = r_marker_good;
        n_conn         = r_conn;
        n_open_ver     = r_open_ver;
        n_param_cursor = r_param_cursor;
        n_param_end    = r_param_end;
        n_cap_cursor   = r_cap_cursor;
        n_cap_header   = r_cap_header;
        n_afi_shift    = r_afi_shift;
        n_remote_as    = r_remote_as;
        n_remote_id    = r_remote_id;
        n_param_type   = r_param_type;
        n_data_start   = r_data_start;
        n_outer_live   = r_outer_live;
        n_inner_live   = r_inner_live;
        n_data_live    = r_data_live;
        put_cap        = 1'b0;
        cap_afi        = '0;
        cap_safi       = '0;
        put_end        = 1'b0;
        end_ev         = bgpd_pkg::EV_CLOSED;
        end_err        = bgpd_pkg::ERR_NONE;

        pos          = r_byte_pos;
        b            = r_byte_pos - bgpd_pkg::HDR_LEN;
        body_bytes   = r_msg_len - bgpd_pkg::HDR_LEN;
        b_plus2      = {1'b0, b} + 17'd2;
        off          = b - r_data_start;
        nxt          = b + 16'd1;
        fin_body_len = '0;

        if (i_accept && r_conn != bgpd_pkg::CONN_CLOSED) begin
            // header and body bytes
            if (pos < 16'd16) begin
                if (i_byte != bgpd_pkg::MARKER_BYTE) n_marker_good = 1'b0;
            end else if (pos == 16'd16) begin
                n_msg_len = {i_byte, 8'h00};
            end else if (pos == 16'd17) begin
                n_msg_len = {r_msg_len[15:8], i_byte};
            end else if (pos == 16'd18) begin
                n_msg_type = i_byte;
                if (!r_marker_good) begin
                    n_conn  = bgpd_pkg::CONN_CLOSED;
                    put_end = 1'b1;
                    end_err = bgpd_pkg::ERR_MARKER;
                end else if (r_msg_len < bgpd_pkg::HDR_LEN
                             || r_msg_len > bgpd_pkg::MAX_MSG_LEN) begin
                    n_conn  = bgpd_pkg::CONN_CLOSED;
                    put_end = 1'b1;
                    end_err = bgpd_pkg::ERR_LENGTH;
                end
            end else if (r_msg_type == bgpd_pkg::MT_OPEN) begin
                if (b == 16'd0) begin
                    n_open_ver = i_byte;
                end else if (r_msg_len >= bgpd_pkg::HDR_LEN + bgpd_pkg::OPEN_MIN_BODY
                             && r_open_ver == bgpd_pkg::BGP_VERSION) begin
                    if (b == 16'd1) begin
                        n_remote_as = {i_byte, 8'h00};
                    end else if (b == 16'd2) begin
                        n_remote_as = {r_remote_as[15:8], i_byte};
                    end else if (b >= 16'd5 && b <= 16'd8) begin
                        n_remote_id = {r_remote_id[23:0], i_byte};
                    end else if (b == 16'd9) begin
                        n_param_end    = 9'd10 + {1'b0, i_byte};
                        n_param_cursor = 16'd10;
                        n_outer_live   = 1'b1;
                        n_inner_live   = 1'b0;
                        n_data_live    = 1'b0;
                    end else if (b >= 16'd10) begin
                        // capability data: AFI at offsets 0..1, SAFI at offset 3
                        if (r_data_live) begin
                            if (off == 16'd0) begin
                                n_afi_shift = {i_byte, 8'h00};
                            end else if (off == 16'd1) begin
                                n_afi_shift = {r_afi_shift[15:8], i_byte};
                            end else if (off == 16'd3) begin
                                put_cap     = 1'b1;
                                cap_afi     = r_afi_shift;
                                cap_safi    = i_byte;
                                n_data_live = 1'b0;
                            end
                        end
                        // capability header walk inside a capabilities parameter
                        if (r_inner_live) begin
                            if (b == r_cap_cursor) begin
                                if (b_plus2 <= {1'b0, r_param_cursor}
                                    && b_plus2 <= {1'b0, body_bytes}) begin
                                    n_cap_header = i_byte;
                                end else begin
                                    n_inner_live = 1'b0;
                                end
                            end else if ({1'b0, b} == {1'b0, r_cap_cursor} + 17'd1) begin
                                if (r_cap_header == bgpd_pkg::CAP_MP
                                    && i_byte >= bgpd_pkg::CAP_MP_MINLEN
                                    && {1'b0, nxt} + 17'd4 <= {1'b0, body_bytes}) begin
                                    n_data_start = nxt;
                                    n_data_live  = 1'b1;
                                end
                                n_cap_cursor = nxt + {8'h00, i_byte};
                            end
                        end
                        // optional parameter walk
                        if (r_outer_live) begin
                            if (b == r_param_cursor) begin
                                n_inner_live = 1'b0;
                                if (b_plus2 <= {8'h00, r_param_end}
                                    && b_plus2 <= {1'b0, body_bytes}) begin
                                    n_param_type = i_byte;
                                end else begin
                                    n_outer_live = 1'b0;
                                end
                            end else if ({1'b0, b} == {1'b0, r_param_cursor} + 17'd1) begin
                                n_param_cursor = nxt + {8'h00, i_byte};
                                if (r_param_type == bgpd_pkg::PARAM_CAPS) begin
                                    n_cap_cursor = nxt;
                                    n_inner_live = 1'b1;
                                end
                            end
                        end
                    end
                end
            end

            // end of message
            if (n_conn != bgpd_pkg::CONN_CLOSED) begin
                if (pos >= 16'd18 && {1'b0, pos} + 17'd1 == {1'b0, n_msg_len}) begin
                    fin_body_len = n_msg_len - bgpd_pkg::HDR_LEN;
                    put_end      = 1'b1;
                    unique case (n_msg_type)
                        bgpd_pkg::MT_OPEN: begin
                            if (fin_body_len < bgpd_pkg::OPEN_MIN_BODY) begin
                                n_conn  = bgpd_pkg::CONN_CLOSED;
                                end_err = bgpd_pkg::ERR_OPEN_SHORT;
                            end else if (n_open_ver != bgpd_pkg::BGP_VERSION) begin
                                n_conn  = bgpd_pkg::CONN_CLOSED;
                                end_err = bgpd_pkg::ERR_VERSION;
                            end else begin
                                n_conn = bgpd_pkg::CONN_OPEN_CONFIRM;
                                end_ev = bgpd_pkg::EV_OPEN_ACCEPT;
                            end
                        end
                        bgpd_pkg::MT_KEEPALIVE: begin
                            if (r_conn == bgpd_pkg::CONN_OPEN_CONFIRM) begin
                                n_conn = bgpd_pkg::CONN_ESTABLISHED;
                                end_ev = bgpd_pkg::EV_ESTABLISHED;
                            end else begin
                                end_ev = bgpd_pkg::EV_KEEPALIVE;
                            end
                        end
                        bgpd_pkg::MT_UPDATE: begin
                            end_ev = bgpd_pkg::EV_UPDATE;
                        end
                        bgpd_pkg::MT_NOTIFICATION: begin
                            n_conn  = bgpd_pkg::CONN_CLOSED;
                            end_err = bgpd_pkg::ERR_NOTIFICATION;
                        end
                        default: begin
                            n_conn  = bgpd_pkg::CONN_CLOSED;
                            end_err = bgpd_pkg::ERR_UNKNOWN_TYPE;
                        end
                    endcase
                    // a closed session is never reframed
                    if (n_conn != bgpd_pkg::CONN_CLOSED) begin
                        n_byte_pos    = '0;
                        n_msg_len     = '0;
                        n_msg_type    = '0;
                        n_marker_good = 1'b1;
                        n_open_ver    = '0;
                        n_outer_live  = 1'b0;
                        n_inner_live  = 1'b0;
                        n_data_live   = 1'b0;
                    end
                end else begin
                    n_byte_pos = pos + 16'd1;
                end
            end
        end

        // result slots: a capability always goes ahead of the message result
        o_push.count = {1'b0, put_cap} + {1'b0, put_end};

        o_push.first.session_state  = bgpd_pkg::conn_code(put_cap ? r_conn : n_conn);
        o_push.first.cap_safi       = put_cap ? cap_safi : 8'h00;
        o_push.first.cap_afi        = put_cap ? cap_afi : 16'h0000;
        o_push.first.peer_router_id = n_remote_id;
        o_push.first.peer_as        = n_remote_as;
        o_push.first.error_code     = put_cap ? bgpd_pkg::ERR_NONE : end_err;
        o_push.first.event_res      = put_cap ? bgpd_pkg::EV_CAPABILITY : end_ev;
        o_push.first.last           = !(put_cap && put_end);

        o_push.second.session_state  = bgpd_pkg::conn_code(n_conn);
        o_push.second.cap_safi       = 8'h00;
        o_push.second.cap_afi        = 16'h0000;
        o_push.second.peer_router_id = n_remote_id;
        o_push.second.peer_as        = n_remote_as;
        o_push.second.error_code     = end_err;
        o_push.second.event_res      = end_ev;
        o_push.second.last           = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_pos     <= '0;
            r_msg_len      <= '0;
            r_msg_type     <= '0;
            r_marker_good  <= 1'b1;
            r_conn         <= bgpd_pkg::CONN_OPEN_SENT;
            r_open_ver     <= '0;
            r_param_cursor <= '0;
            r_param_end    <= '0;
            r_cap_cursor   <= '0;
            r_cap_header   <= '0;
            r_afi_shift    <= '0;
            r_remote_as    <= '0;
            r_remote_id    <= '0;
            r_param_type   <= '0;
            r_data_start   <= '0;
            r_outer_live   <= 1'b0;
            r_inner_live   <= 1'b0;
            r_data_live    <= 1'b0;
        end else begin
            r_byte_pos     <= n_byte_pos;
            r_msg_len      <= n_msg_len;
            r_msg_type     <= n_msg_type;
            r_marker_good  <= n_marker_good;
            r_conn         <= n_conn;
            r_open_ver     <= n_open_ver;
            r_param_cursor <= n_param_cursor;
            r_param_end    <= n_param_end;
            r_cap_cursor   <= n_cap_cursor;
            r_cap_header   <= n_cap_header;
            r_afi_shift    <= n_afi_shift;
            r_remote_as    <= n_remote_as;
            r_remote_id    <= n_remote_id;
            r_param_type   <= n_param_type;
            r_data_start   <= n_data_start;
            r_outer_live   <= n_outer_live;
            r_inner_live   <= n_inner_live;
            r_data_live    <= n_data_live;
        end
    end

endmodule

>>> rtl/bgpd_outq.sv
// Four-entry result queue; takes up to two results per cycle, gives one when the reader is ready.
module bgpd_outq (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  bgpd_pkg::t_push     i_push,
    output logic                o_in_ready,
    output logic                o_valid,
    input  logic                i_ready,
    output bgpd_pkg::t_result   o_result
);

    bgpd_pkg::t_result r_mem [4];
    logic [1:0] r_wr_ptr, n_wr_ptr;
    logic [1:0] r_rd_ptr, n_rd_ptr;
    logic [2:0] r_count,  n_count;
    logic       pop;

    // room for two more results whatever this cycle brings
    assign o_in_ready = (r_count <= 3'd2);
    assign o_valid    = (r_count != 3'd0);
    assign o_result   = r_mem[r_rd_ptr];
    assign pop        = o_valid && i_ready;

    always_comb begin
        n_wr_ptr = r_wr_ptr + i_push.count;
        n_rd_ptr = r_rd_ptr + {1'b0, pop};
        n_count  = r_count + {1'b0, i_push.count} - {2'b00, pop};
    end

    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) r_mem[r_wr_ptr] <= i_push.first;
        if (i_push.count == 2'd2) r_mem[r_wr_ptr + 2'd1] <= i_push.second;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

>>> rtl/bgp_message_deframer_fsm_unit.sv
// Results of a byte enter the result queue at the edge that accepts it and are
// presented from the next cycle. One byte per cycle is accepted while the queue has two
// free slots; a byte with two results (a capability at the last byte of an OPEN) queues
// both, and they are presented one at a time. Input readiness is set by the four-entry
// result queue, which must hold two free slots. Reset (synchronous, active low) returns
// to open sent with an empty queue; a closed session ignores all bytes until reset.
module bgp_message_deframer_fsm_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] data_byte
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // [2:0] event_res, [5:3] error_code, [21:6] peer_as, [53:22] peer_router_id,
    // [69:54] cap_afi, [77:70] cap_safi, [79:78] session_state
    output logic [79:0] o_m_axis_tdata,
    output logic        o_m_axis_tlast
);

    bgpd_pkg::t_push   push;
    bgpd_pkg::t_result head;
    logic              in_ready;
    logic              accept;

    assign accept          = i_s_axis_tvalid && in_ready;
    assign o_s_axis_tready = in_ready;

    bgpd_parser u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_byte   (i_s_axis_tdata),
        .o_push   (push)
    );

    bgpd_outq u_outq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .o_in_ready (in_ready),
        .o_valid    (o_m_axis_tvalid),
        .i_ready    (i_m_axis_tready),
        .o_result   (head)
    );

    assign o_m_axis_tdata = {head.session_state, head.cap_safi, head.cap_afi,
                             head.peer_router_id, head.peer_as, head.error_code,
                             head.event_res};
    assign o_m_axis_tlast = head.last;

endmodule
